// ----- rtl/era_pkg.sv -----
// ----------------------------------------------------------------------------
// era_pkg
// Types and constants shared by the echo reply accounting block.
// ----------------------------------------------------------------------------
package era_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IDENTIFIER     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PAYLOAD_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMING_ON      = 2'd2;

   localparam logic [15:0] IDENTIFIER_RESET     = 16'd0;
   localparam logic [15:0] PAYLOAD_LENGTH_RESET = 16'd56;
   localparam logic [16:0] ICMP_HEADER_BYTES    = 17'd8;

   // Request opcodes.
   localparam logic OP_SEND    = 1'b0;
   localparam logic OP_RECEIVE = 1'b1;

   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

   // Time arithmetic.
   localparam logic [21:0] USEC_PER_SEC   = 22'd1000000;
   localparam logic [48:0] TICKS_PER_SEC  = 49'd10000;
   // Division by 100 as multiply by ceil(2^28 / 100), exact below 2^21.
   localparam logic [21:0] DIV100_MUL     = 22'd2684355;
   localparam int          DIV100_SHIFT   = 28;

   typedef enum logic [2:0] {
      ST_SENT    = 3'd0,
      ST_NEW     = 3'd1,
      ST_DUP     = 3'd2,
      ST_SHORT   = 3'd3,
      ST_FOREIGN = 3'd4
   } status_type;

   // Operands of the round trip computation.
   typedef struct packed {
      logic [33:0] sec_diff;   // two's complement seconds after borrow
      logic [20:0] usec_mag;   // magnitude of the microsecond difference
      logic        usec_neg;   // sign of the microsecond difference
   } trip_arg_type;

   typedef struct packed {
      logic [31:0] min_trip;
      logic [31:0] max_trip;
      logic [47:0] sum_trip;
   } stats_type;

endpackage

// ----- rtl/era_bitmap.sv -----
// ----------------------------------------------------------------------------
// era_bitmap
// Duplicate window: one bit per sequence slot in a synchronous RAM, with a
// clearing sweep after reset and forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module era_bitmap
   import era_pkg::*;
#(
   parameter int DUP_WINDOW = 1024
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(DUP_WINDOW)-1:0] rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(DUP_WINDOW)-1:0] wr_addr,
   input  logic                          wr_data,
   output logic                          seen,
   output logic                          busy
);

   localparam int SLOT_BITS = $clog2(DUP_WINDOW);

   logic                 mem [DUP_WINDOW];
   logic                 rd_data_ff;
   logic                 fwd_hit_ff;
   logic                 fwd_data_ff;
   logic                 busy_ff;
   logic [SLOT_BITS-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // A write landing on the edge of the read is not seen by the RAM output.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + SLOT_BITS'(1);
         if (clr_addr_ff == SLOT_BITS'(DUP_WINDOW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign seen = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign busy = busy_ff;

endmodule

// ----- rtl/era_trip.sv -----
// ----------------------------------------------------------------------------
// era_trip
// Two-stage round trip unit: scale seconds and divide microseconds by 100,
// then add and clamp the result to 32 bits.
// ----------------------------------------------------------------------------
module era_trip
   import era_pkg::*;
(
   input  logic         clock,
   input  logic         load_mul,
   input  logic         load_sum,
   input  trip_arg_type arg,
   output logic [31:0]  trip
);

   logic [48:0] sec_part_ff;
   logic [42:0] usec_prod_ff;
   logic        usec_neg_ff;
   logic [31:0] trip_ff;

   logic [48:0] sec_ext;
   logic [48:0] usec_quot;
   logic [48:0] total;
   logic [31:0] trip_in;

   assign sec_ext = {{15{arg.sec_diff[33]}}, arg.sec_diff};

   always_ff @(posedge clock) begin
      if (load_mul) begin
         sec_part_ff  <= sec_ext * TICKS_PER_SEC;
         usec_prod_ff <= 43'(arg.usec_mag) * 43'(DIV100_MUL);
         usec_neg_ff  <= arg.usec_neg;
      end
   end

   always_comb begin
      usec_quot = 49'(usec_prod_ff[42:DIV100_SHIFT]);
      total     = usec_neg_ff ? (sec_part_ff - usec_quot) : (sec_part_ff + usec_quot);
      if (total[48]) begin
         trip_in = '0;
      end else if (|total[47:32]) begin
         trip_in = '1;
      end else begin
         trip_in = total[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_sum) begin
         trip_ff <= trip_in;
      end
   end

   assign trip = trip_ff;

endmodule

// ----- rtl/era_stats.sv -----
// ----------------------------------------------------------------------------
// era_stats
// Minimum, maximum and saturating sum of the measured round trips.
// ----------------------------------------------------------------------------
module era_stats
   import era_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        commit,
   input  logic        upd_en,
   input  logic [31:0] trip,
   output stats_type   nxt
);

   stats_type   stats_ff;
   logic [48:0] sum_wide;

   assign sum_wide = {1'b0, stats_ff.sum_trip} + 49'(trip);

   always_comb begin
      nxt = stats_ff;
      if (upd_en) begin
         nxt.sum_trip = sum_wide[48] ? '1 : sum_wide[47:0];
         if (trip < stats_ff.min_trip) begin
            nxt.min_trip = trip;
         end
         if (trip > stats_ff.max_trip) begin
            nxt.max_trip = trip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff.min_trip <= '1;
         stats_ff.max_trip <= '0;
         stats_ff.sum_trip <= '0;
      end else if (commit) begin
         stats_ff <= nxt;
      end
   end

endmodule

// ----- rtl/echo_reply_accounting.sv -----
// ----------------------------------------------------------------------------
// echo_reply_accounting
// Echo request/reply accounting: sequence numbering, duplicate detection and
// round trip statistics.
// ----------------------------------------------------------------------------
// Usage: each req_ item is either a send event (req_opcode 0) or a received
// packet (req_opcode 1). Every item produces exactly one rsp_ item, in order,
// carrying the status, the sequence number, the trip time and a snapshot of
// all counters and statistics after that item.
// The csr_ channel writes identifier, payload length and timing enable; it is
// always ready and should only be used while no item is in flight.
// Timing: a five-stage pipeline (input, slot reduce, bitmap RAM read-modify-
// write, trip add and clamp, output register). One item per cycle is
// sustained while rsp_ready is high; the bitmap RAM does one read and one
// write per cycle with same-slot forwarding.
// Reset: the counters and statistics clear at once, then the duplicate window
// is swept clear one slot per cycle, with req_ready low.
// Backpressure: when rsp_ready is low, items keep entering until every stage
// holds one; the result in the output register stays unchanged until taken.
// ----------------------------------------------------------------------------
module echo_reply_accounting
   import era_pkg::*;
#(
   parameter int DUP_WINDOW = 1024
)(
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [15:0]               req_packet_length,
   input  logic [7:0]                req_msg_type,
   input  logic [15:0]               req_reply_id,
   input  logic [15:0]               req_reply_seq,
   input  logic [31:0]               req_now_sec,
   input  logic [19:0]               req_now_usec,
   input  logic [31:0]               req_stamp_sec,
   input  logic [19:0]               req_stamp_usec,
   // Response channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [15:0]               rsp_sequence_res,
   output logic [31:0]               rsp_trip_time,
   output logic [31:0]               rsp_sent_total,
   output logic [31:0]               rsp_received_total,
   output logic [31:0]               rsp_repeat_total,
   output logic [31:0]               rsp_min_trip,
   output logic [31:0]               rsp_max_trip,
   output logic [47:0]               rsp_sum_trip,
   // Configuration channel.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data
);

   localparam int SLOT_BITS = $clog2(DUP_WINDOW);
   // Slot = seq mod DUP_WINDOW via multiply by ceil(2^32 / DUP_WINDOW).
   localparam logic [28:0] SLOT_MUL =
      29'(((64'd1 << 32) + 64'(DUP_WINDOW) - 64'd1) / 64'(DUP_WINDOW));

   // Configuration registers.
   logic [15:0] identifier_ff;
   logic [15:0] payload_length_ff;
   logic        timing_on_ff;

   // Pipeline handshake.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic mv1, mv2, mv3, mv4;
   logic accept;
   logic clearing;

   // Stage 1.
   status_type  s1_status_ff;
   logic [15:0] s1_seq_ff;
   logic        s1_timing_ff;
   logic [31:0] s1_now_sec_ff, s1_stamp_sec_ff;
   logic [19:0] s1_now_usec_ff, s1_stamp_usec_ff;
   status_type  s1_status_in;
   logic        short_pkt;

   // Stage 2.
   status_type   s2_status_ff;
   logic [15:0]  s2_seq_ff;
   logic         s2_timing_ff;
   logic [12:0]  s2_quot_ff;
   trip_arg_type s2_arg_ff;
   trip_arg_type arg_in;
   logic [20:0]  usec_diff;
   logic [21:0]  usec_adj;
   logic [21:0]  usec_abs;
   logic [44:0]  quot_prod;
   logic [31:0]  quot_scaled;
   logic [31:0]  slot_rem;
   logic [SLOT_BITS-1:0] s2_slot;

   // Stage 3.
   status_type           s3_status_ff;
   logic [15:0]          s3_seq_ff;
   logic                 s3_timing_ff;
   logic [SLOT_BITS-1:0] s3_slot_ff;
   logic                 is_send3, is_reply3, seen;
   status_type           s3_status_res;
   logic [15:0]          s3_seq_res;
   logic                 bm_rd_en, bm_wr_en;
   logic [SLOT_BITS-1:0] bm_wr_addr;

   // Counters.
   logic [31:0]          tx_count_ff, rx_count_ff, dup_count_ff;
   logic [31:0]          tx_count_in, rx_count_in, dup_count_in;
   logic [SLOT_BITS-1:0] tx_slot_ff, tx_slot_in;

   // Stage 4.
   status_type  s4_status_ff;
   logic [15:0] s4_seq_ff;
   logic        s4_upd_ff;
   logic [31:0] s4_tx_ff, s4_rx_ff, s4_dup_ff;
   logic [31:0] trip;
   stats_type   stats_nxt;

   // Output register.
   status_type  rsp_status_ff;
   logic [15:0] rsp_seq_ff;
   logic [31:0] rsp_trip_ff;
   logic [31:0] rsp_tx_ff, rsp_rx_ff, rsp_dup_ff;
   stats_type   rsp_stats_ff;

   // ------------------------------------------------------------------------
   // Configuration.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         identifier_ff     <= IDENTIFIER_RESET;
         payload_length_ff <= PAYLOAD_LENGTH_RESET;
         timing_on_ff      <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IDENTIFIER:     identifier_ff     <= csr_data;
            REG_PAYLOAD_LENGTH: payload_length_ff <= csr_data;
            REG_TIMING_ON:      timing_on_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control: a stage takes a new item when empty or moving on.
   // ------------------------------------------------------------------------
   assign rdy4 = !rsp_valid_ff || rsp_ready;
   assign rdy3 = !s4_valid_ff || rdy4;
   assign rdy2 = !s3_valid_ff || rdy3;
   assign rdy1 = !s2_valid_ff || rdy2;
   assign mv4  = s4_valid_ff && rdy4;
   assign mv3  = s3_valid_ff && rdy3;
   assign mv2  = s2_valid_ff && rdy2;
   assign mv1  = s1_valid_ff && rdy1;

   assign req_ready = (!s1_valid_ff || rdy1) && !clearing;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (mv1) begin
            s1_valid_ff <= 1'b0;
         end
         if (mv1) begin
            s2_valid_ff <= 1'b1;
         end else if (mv2) begin
            s2_valid_ff <= 1'b0;
         end
         if (mv2) begin
            s3_valid_ff <= 1'b1;
         end else if (mv3) begin
            s3_valid_ff <= 1'b0;
         end
         if (mv3) begin
            s4_valid_ff <= 1'b1;
         end else if (mv4) begin
            s4_valid_ff <= 1'b0;
         end
         if (mv4) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: classify the item.
   // ------------------------------------------------------------------------
   assign short_pkt = {1'b0, req_packet_length} < ({1'b0, payload_length_ff} + ICMP_HEADER_BYTES);

   always_comb begin
      priority if (req_opcode == OP_SEND) begin
         s1_status_in = ST_SENT;
      end else if (short_pkt) begin
         s1_status_in = ST_SHORT;
      end else if (req_msg_type != ICMP_ECHO_REPLY || req_reply_id != identifier_ff) begin
         s1_status_in = ST_FOREIGN;
      end else begin
         // Ours; new or repeat is decided against the bitmap later.
         s1_status_in = ST_NEW;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff     <= s1_status_in;
         s1_seq_ff        <= req_reply_seq;
         s1_timing_ff     <= timing_on_ff;
         s1_now_sec_ff    <= req_now_sec;
         s1_now_usec_ff   <= req_now_usec;
         s1_stamp_sec_ff  <= req_stamp_sec;
         s1_stamp_usec_ff <= req_stamp_usec;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: time differences with borrow, and slot quotient.
   // ------------------------------------------------------------------------
   always_comb begin
      usec_diff       = {1'b0, s1_now_usec_ff} - {1'b0, s1_stamp_usec_ff};
      usec_adj        = {usec_diff[20], usec_diff} + (usec_diff[20] ? USEC_PER_SEC : 22'd0);
      usec_abs        = usec_adj[21] ? (22'd0 - usec_adj) : usec_adj;
      arg_in.sec_diff = {2'b00, s1_now_sec_ff} - {2'b00, s1_stamp_sec_ff}
                        - 34'(usec_diff[20]);
      arg_in.usec_mag = usec_abs[20:0];
      arg_in.usec_neg = usec_adj[21];
      quot_prod       = 45'(s1_seq_ff) * 45'(SLOT_MUL);
   end

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_status_ff <= s1_status_ff;
         s2_seq_ff    <= s1_seq_ff;
         s2_timing_ff <= s1_timing_ff;
         s2_arg_ff    <= arg_in;
         s2_quot_ff   <= quot_prod[44:32];
      end
   end

   assign quot_scaled = 32'(s2_quot_ff) * 32'(DUP_WINDOW);
   assign slot_rem    = 32'(s2_seq_ff) - quot_scaled;
   assign s2_slot     = slot_rem[SLOT_BITS-1:0];
   assign bm_rd_en    = mv2 && (s2_status_ff == ST_NEW);

   always_ff @(posedge clock) begin
      if (mv2) begin
         s3_status_ff <= s2_status_ff;
         s3_seq_ff    <= s2_seq_ff;
         s3_timing_ff <= s2_timing_ff;
         s3_slot_ff   <= s2_slot;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: bitmap decision, write back and counters.
   // ------------------------------------------------------------------------
   era_bitmap #(
      .DUP_WINDOW (DUP_WINDOW)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (bm_rd_en),
      .rd_addr (s2_slot),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (is_reply3),
      .seen    (seen),
      .busy    (clearing)
   );

   assign is_send3   = (s3_status_ff == ST_SENT);
   assign is_reply3  = (s3_status_ff == ST_NEW);
   assign bm_wr_en   = mv3 && (is_send3 || is_reply3);
   assign bm_wr_addr = is_send3 ? tx_slot_ff : s3_slot_ff;

   always_comb begin
      s3_status_res = s3_status_ff;
      s3_seq_res    = '0;
      if (is_send3) begin
         s3_seq_res = tx_count_ff[15:0];
      end else if (is_reply3) begin
         s3_seq_res    = s3_seq_ff;
         s3_status_res = seen ? ST_DUP : ST_NEW;
      end
      tx_count_in  = tx_count_ff + 32'(is_send3);
      rx_count_in  = rx_count_ff + 32'(is_reply3 && !seen);
      dup_count_in = dup_count_ff + 32'(is_reply3 && seen);
      // The send slot follows the 16-bit sequence modulo the window.
      if (tx_count_ff[15:0] == 16'hFFFF || tx_slot_ff == SLOT_BITS'(DUP_WINDOW - 1)) begin
         tx_slot_in = '0;
      end else begin
         tx_slot_in = tx_slot_ff + SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_count_ff  <= '0;
         rx_count_ff  <= '0;
         dup_count_ff <= '0;
         tx_slot_ff   <= '0;
      end else if (mv3) begin
         tx_count_ff  <= tx_count_in;
         rx_count_ff  <= rx_count_in;
         dup_count_ff <= dup_count_in;
         if (is_send3) begin
            tx_slot_ff <= tx_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mv3) begin
         s4_status_ff <= s3_status_res;
         s4_seq_ff    <= s3_seq_res;
         s4_upd_ff    <= is_reply3 && s3_timing_ff;
         s4_tx_ff     <= tx_count_in;
         s4_rx_ff     <= rx_count_in;
         s4_dup_ff    <= dup_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Round trip unit: multiplies on entry to stage 3, sum on entry to stage 4.
   // ------------------------------------------------------------------------
   era_trip u_trip (
      .clock    (clock),
      .load_mul (mv2),
      .load_sum (mv3),
      .arg      (s2_arg_ff),
      .trip     (trip)
   );

   // ------------------------------------------------------------------------
   // Stage 4: statistics and output register.
   // ------------------------------------------------------------------------
   era_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .commit (mv4),
      .upd_en (s4_upd_ff),
      .trip   (trip),
      .nxt    (stats_nxt)
   );

   always_ff @(posedge clock) begin
      if (mv4) begin
         rsp_status_ff <= s4_status_ff;
         rsp_seq_ff    <= s4_seq_ff;
         rsp_trip_ff   <= s4_upd_ff ? trip : 32'd0;
         rsp_tx_ff     <= s4_tx_ff;
         rsp_rx_ff     <= s4_rx_ff;
         rsp_dup_ff    <= s4_dup_ff;
         rsp_stats_ff  <= stats_nxt;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sequence_res   = rsp_seq_ff;
   assign rsp_trip_time      = rsp_trip_ff;
   assign rsp_sent_total     = rsp_tx_ff;
   assign rsp_received_total = rsp_rx_ff;
   assign rsp_repeat_total   = rsp_dup_ff;
   assign rsp_min_trip       = rsp_stats_ff.min_trip;
   assign rsp_max_trip       = rsp_stats_ff.max_trip;
   assign rsp_sum_trip       = rsp_stats_ff.sum_trip;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echo reply accounting block. A built-in ledger
// mirrors the sequence counter, duplicate window and trip statistics, predicts
// one report per accepted item and compares every returned report field by
// field. Directed corner items come first, then random phases under several
// register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import era_pkg::*;

   localparam int WINDOW_SLOTS     = 1024;
   localparam int RESULT_LATENCY   = 4;
   localparam int HEADER_BYTES     = 8;
   localparam int PHASE_COUNT      = 8;
   localparam int PHASE_ITEMS      = 66;
   localparam int RUN_LIMIT        = 40000;
   localparam longint USEC_IN_SECOND = 1000000;
   localparam longint TICKS_IN_SECOND = 10000;
   localparam longint USEC_IN_TICK   = 100;
   localparam longint TRIP_CEILING   = 64'h0000_0000_FFFF_FFFF;
   localparam longint unsigned SUM_CEILING = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic        opcode;
      logic [15:0] packet_length;
      logic [7:0]  msg_type;
      logic [15:0] reply_id;
      logic [15:0] reply_seq;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
      logic [31:0] stamp_sec;
      logic [19:0] stamp_usec;
   } echo_event_type;

   typedef struct {
      status_type  status;
      logic [15:0] sequence_res;
      logic [31:0] trip_time;
      logic [31:0] sent_total;
      logic [31:0] received_total;
      logic [31:0] repeat_total;
      logic [31:0] min_trip;
      logic [31:0] max_trip;
      logic [47:0] sum_trip;
   } echo_report_type;

   // Mirror of the accounting state; predicts the report of each item.
   class echo_ledger;
      logic [15:0]     echo_id;
      logic [15:0]     payload_len;
      logic            timing_enabled;
      logic [31:0]     sent_count;
      logic [31:0]     fresh_count;
      logic [31:0]     dup_count;
      logic [31:0]     trip_low;
      logic [31:0]     trip_high;
      longint unsigned trip_total;
      bit              seen_slots [WINDOW_SLOTS];
      echo_report_type pending_reports [$];
      int              mismatches;

      function new();
         echo_id        = IDENTIFIER_RESET;
         payload_len    = PAYLOAD_LENGTH_RESET;
         timing_enabled = 1'b1;
         sent_count     = '0;
         fresh_count    = '0;
         dup_count      = '0;
         trip_low       = '1;
         trip_high      = '0;
         trip_total     = 0;
         mismatches     = 0;
         foreach (seen_slots[i]) seen_slots[i] = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] data);
         case (idx)
            REG_IDENTIFIER: begin
               echo_id = data;
            end
            REG_PAYLOAD_LENGTH: begin
               payload_len = data;
            end
            REG_TIMING_ON: begin
               timing_enabled = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      // Microsecond difference borrows a second when negative; division
      // truncates toward zero before the clamp to the 32-bit range.
      function logic [31:0] trip_ticks(logic [31:0] nsec, logic [19:0] nus,
                                       logic [31:0] ssec, logic [19:0] sus);
         longint sec_delta;
         longint usec_delta;
         longint ticks;
         sec_delta  = longint'(nsec) - longint'(ssec);
         usec_delta = longint'(nus) - longint'(sus);
         if (usec_delta < 0) begin
            sec_delta  = sec_delta - 1;
            usec_delta = usec_delta + USEC_IN_SECOND;
         end
         ticks = sec_delta * TICKS_IN_SECOND + usec_delta / USEC_IN_TICK;
         if (ticks < 0) return '0;
         if (ticks > TRIP_CEILING) return '1;
         return ticks[31:0];
      endfunction

      function void record_event(echo_event_type ev);
         echo_report_type want;
         int              slot;
         longint unsigned grown;
         want.sequence_res = '0;
         want.trip_time    = '0;
         if (ev.opcode == OP_SEND) begin
            want.sequence_res = sent_count[15:0];
            seen_slots[int'(sent_count[15:0]) % WINDOW_SLOTS] = 1'b0;
            sent_count  = sent_count + 1;
            want.status = ST_SENT;
         end else if (int'(ev.packet_length) < int'(payload_len) + HEADER_BYTES) begin
            want.status = ST_SHORT;
         end else if (ev.msg_type != ICMP_ECHO_REPLY || ev.reply_id != echo_id) begin
            want.status = ST_FOREIGN;
         end else begin
            slot = int'(ev.reply_seq) % WINDOW_SLOTS;
            want.sequence_res = ev.reply_seq;
            if (timing_enabled) begin
               want.trip_time = trip_ticks(ev.now_sec, ev.now_usec,
                                           ev.stamp_sec, ev.stamp_usec);
               grown = trip_total + longint'(want.trip_time);
               trip_total = (grown > SUM_CEILING) ? SUM_CEILING : grown;
               if (want.trip_time < trip_low) trip_low = want.trip_time;
               if (want.trip_time > trip_high) trip_high = want.trip_time;
            end
            if (seen_slots[slot]) begin
               dup_count   = dup_count + 1;
               want.status = ST_DUP;
            end else begin
               seen_slots[slot] = 1'b1;
               fresh_count = fresh_count + 1;
               want.status = ST_NEW;
            end
         end
         want.sent_total     = sent_count;
         want.received_total = fresh_count;
         want.repeat_total   = dup_count;
         want.min_trip       = trip_low;
         want.max_trip       = trip_high;
         want.sum_trip       = trip_total[47:0];
         pending_reports.insert(pending_reports.size(), want);
      endfunction

      function void compare(string field, logic [47:0] want, logic [47:0] got);
         if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      function void check_report(echo_report_type got);
         echo_report_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            $error("report arrived with no item outstanding");
            return;
         end
         want = pending_reports.pop_front();
         compare("status", want.status, got.status);
         compare("sequence_res", want.sequence_res, got.sequence_res);
         compare("trip_time", want.trip_time, got.trip_time);
         compare("sent_total", want.sent_total, got.sent_total);
         compare("received_total", want.received_total, got.received_total);
         compare("repeat_total", want.repeat_total, got.repeat_total);
         compare("min_trip", want.min_trip, got.min_trip);
         compare("max_trip", want.max_trip, got.max_trip);
         compare("sum_trip", want.sum_trip, got.sum_trip);
      endfunction

      function int backlog();
         return pending_reports.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = OP_SEND;
   logic [15:0]               req_packet_length = '0;
   logic [7:0]                req_msg_type = '0;
   logic [15:0]               req_reply_id = '0;
   logic [15:0]               req_reply_seq = '0;
   logic [31:0]               req_now_sec = '0;
   logic [19:0]               req_now_usec = '0;
   logic [31:0]               req_stamp_sec = '0;
   logic [19:0]               req_stamp_usec = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_status;
   logic [15:0]               rsp_sequence_res;
   logic [31:0]               rsp_trip_time;
   logic [31:0]               rsp_sent_total;
   logic [31:0]               rsp_received_total;
   logic [31:0]               rsp_repeat_total;
   logic [31:0]               rsp_min_trip;
   logic [31:0]               rsp_max_trip;
   logic [47:0]               rsp_sum_trip;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0]               csr_data = '0;

   echo_ledger  ledger = new();
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic [15:0] cur_identifier = IDENTIFIER_RESET;
   logic [15:0] cur_payload = PAYLOAD_LENGTH_RESET;
   int          sends_issued = 0;
   int          cycle_count = 0;

   echo_reply_accounting #(.DUP_WINDOW(WINDOW_SLOTS)) uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_report('{status: status_type'(rsp_status),
                               sequence_res: rsp_sequence_res,
                               trip_time: rsp_trip_time,
                               sent_total: rsp_sent_total,
                               received_total: rsp_received_total,
                               repeat_total: rsp_repeat_total,
                               min_trip: rsp_min_trip,
                               max_trip: rsp_max_trip,
                               sum_trip: rsp_sum_trip});
      rsp_ready <= !($urandom_range(0, 99) < receiver_stall_pct);
   end

   function automatic echo_event_type pack_event(logic op, logic [15:0] plen,
                                                 logic [7:0] itype, logic [15:0] rid,
                                                 logic [15:0] seq, logic [31:0] nsec,
                                                 logic [19:0] nus, logic [31:0] ssec,
                                                 logic [19:0] sus);
      echo_event_type ev;
      ev = '{op, plen, itype, rid, seq, nsec, nus, ssec, sus};
      return ev;
   endfunction

   // Mostly sends and well-formed replies to recent sends, with near misses
   // and fully random noise mixed in.
   function automatic echo_event_type random_event();
      echo_event_type ev;
      int             pick;
      int             min_len;
      int             want_len;
      pick    = $urandom_range(0, 99);
      min_len = int'(cur_payload) + HEADER_BYTES;
      want_len = min_len + $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) want_len = min_len;
      if (want_len > 65535) want_len = 65535;
      ev.opcode        = OP_RECEIVE;
      ev.packet_length = (min_len > 65535) ? 16'($urandom) : 16'(want_len);
      ev.msg_type      = ICMP_ECHO_REPLY;
      ev.reply_id      = cur_identifier;
      ev.reply_seq     = 16'(sends_issued - 1 - $urandom_range(0, 3));
      ev.stamp_sec     = $urandom;
      ev.now_sec       = ev.stamp_sec + 32'($urandom_range(0, 3));
      ev.stamp_usec    = 20'($urandom_range(0, 999999));
      ev.now_usec      = 20'($urandom_range(0, 999999));
      if (pick < 30) begin
         ev.opcode = OP_SEND;
      end else if (pick < 68) begin
      end else if (pick < 76) begin
         ev.reply_seq = 16'($urandom);
      end else if (pick < 80) begin
         if (min_len >= 1 && min_len <= 65536) ev.packet_length = 16'(min_len - 1);
      end else if (pick < 84) begin
         ev.msg_type = 8'($urandom_range(1, 255));
      end else if (pick < 88) begin
         ev.reply_id = cur_identifier ^ (16'd1 << $urandom_range(0, 15));
      end else begin
         ev = pack_event(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), $urandom, 20'($urandom),
                         $urandom, 20'($urandom));
      end
      return ev;
   endfunction

   task automatic issue_event(echo_event_type ev);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= ev.opcode;
      req_packet_length <= ev.packet_length;
      req_msg_type      <= ev.msg_type;
      req_reply_id      <= ev.reply_id;
      req_reply_seq     <= ev.reply_seq;
      req_now_sec       <= ev.now_sec;
      req_now_usec      <= ev.now_usec;
      req_stamp_sec     <= ev.stamp_sec;
      req_stamp_usec    <= ev.stamp_usec;
      do @(posedge clock); while (!req_ready);
      ledger.record_event(ev);
      if (ev.opcode == OP_SEND) sends_issued++;
   endtask

   // Leaves csr_valid high so back-to-back writes need one assignment per edge.
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      ledger.write_register(idx, data);
   endtask

   task automatic apply_settings(logic [15:0] id, logic [15:0] plen, logic timing);
      write_csr(REG_IDENTIFIER, id);
      write_csr(REG_PAYLOAD_LENGTH, plen);
      write_csr(REG_TIMING_ON, (16'($urandom) & 16'hFFFE) | 16'(timing));
      write_csr(REG_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
      cur_identifier = id;
      cur_payload    = plen;
   endtask

   task automatic wait_for_drain();
      while (ledger.backlog() != 0) @(posedge clock);
      repeat (RESULT_LATENCY * 2) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corner items under the reset settings: identifier 0, payload 56.
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'd5,
                             32'd10, 20'd500000, 32'd10, 20'd100000));
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'd5,
                             32'd10, 20'd500000, 32'd10, 20'd100000));
      issue_event(pack_event(OP_SEND, '0, '0, '0, '0, '0, '0, '0, '0));
      issue_event(pack_event(OP_SEND, '1, '1, '1, '1, '1, '1, '1, '1));
      issue_event(pack_event(OP_RECEIVE, 16'hFFFF, ICMP_ECHO_REPLY, 16'd0, 16'd0,
                             32'd20, 20'd100, 32'd19, 20'd999999));
      // Sequence 1024 shares a window slot with sequence 0.
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'd1024,
                             32'd5, 20'd0, 32'd6, 20'd0));
      issue_event(pack_event(OP_SEND, '0, '0, '0, '0, '0, '0, '0, '0));
      issue_event(pack_event(OP_RECEIVE, 16'd100, ICMP_ECHO_REPLY, 16'd0, 16'd2,
                             32'hFFFF_FFFF, 20'hFFFFF, 32'd0, 20'd0));
      issue_event(pack_event(OP_RECEIVE, 16'd63, ICMP_ECHO_REPLY, 16'd0, 16'd2,
                             32'd1, 20'd0, 32'd0, 20'd0));
      issue_event(pack_event(OP_RECEIVE, 16'd0, ICMP_ECHO_REPLY, 16'd0, 16'd2,
                             32'd1, 20'd0, 32'd0, 20'd0));
      issue_event(pack_event(OP_RECEIVE, 16'd64, 8'd8, 16'd0, 16'd1,
                             32'd1, 20'd0, 32'd0, 20'd0));
      issue_event(pack_event(OP_RECEIVE, 16'd64, 8'hFF, 16'd0, 16'd1,
                             32'd1, 20'd0, 32'd0, 20'd0));
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'hFFFF, 16'd1,
                             32'd1, 20'd0, 32'd0, 20'd0));
      // Microsecond fields beyond one second are used as given.
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'hFFFF,
                             32'd102, 20'd0, 32'd100, 20'hFFFFF));
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'd3,
                             32'd7, 20'd99, 32'd7, 20'd0));
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'd3,
                             32'd7, 20'd0, 32'd7, 20'd99));
      issue_event(pack_event(OP_SEND, '0, '0, '0, '0, '0, '0, '0, '0));
      issue_event(pack_event(OP_RECEIVE, 16'd64, ICMP_ECHO_REPLY, 16'd0, 16'd3,
                             32'd9, 20'd12345, 32'd8, 20'd999999));
      issue_event(pack_event(OP_RECEIVE, 16'd1500, ICMP_ECHO_REPLY, 16'd0, 16'hAAAA,
                             32'h5555_5555, 20'h55555, 32'h5555_5554, 20'hAAAAA));
      req_valid <= 1'b0;
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         sender_idle_pct    = (phase % 4 == 1) ? 73 : ((phase % 4 == 3) ? 18 : 0);
         receiver_stall_pct = (phase % 4 == 2) ? 73 : ((phase % 4 == 3) ? 18 : 0);
         case (phase)
            0: apply_settings(16'($urandom), 16'd56, 1'b1);
            1: apply_settings(16'hFFFF, 16'd0, 1'b1);
            2: apply_settings(16'd0, 16'hFFFF, 1'b1);
            3: apply_settings(16'($urandom), 16'($urandom_range(0, 1400)), 1'b0);
            4: apply_settings(16'($urandom), 16'($urandom_range(0, 200)), 1'b1);
            5: apply_settings(16'hFFFF, 16'hFFF7, 1'b1);
            6: apply_settings(16'($urandom), 16'd56, 1'b0);
            default: apply_settings(16'($urandom), 16'($urandom_range(0, 1000)), 1'b1);
         endcase
         repeat (PHASE_ITEMS) issue_event(random_event());
         req_valid <= 1'b0;
         wait_for_drain();
      end

      repeat (RESULT_LATENCY * 2) @(posedge clock);

      if (ledger.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/era_pkg.sv
rtl/era_bitmap.sv
rtl/era_trip.sv
rtl/era_stats.sv
rtl/echo_reply_accounting.sv
bench/tb_top.sv
